### design/bitplane_sign_magnitude_pack_top_defines.svh
// ----------------------------------------------------------------------------
// Bitplane packer assertion macros
// Shared macros for the concurrent assertions of the bitplane packer.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_SIGN_MAGNITUDE_PACK_TOP_DEFINES_SVH
`define BITPLANE_SIGN_MAGNITUDE_PACK_TOP_DEFINES_SVH

// Assertion that is disabled while reset is high.
`define BSMP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked while reset is high.
`define BSMP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/bsmp_pkg.sv
// ----------------------------------------------------------------------------
// Bitplane packer package
// Sizes, shared types and helper functions of the bitplane packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmp_pkg;

   localparam int LANES      = 8;
   localparam int MAX_PLANES = 16;
   localparam int SAMPLE_W   = 16;
   localparam int PLANE_W    = 5;
   localparam int GROUP_W    = 12;
   localparam int COUNT_W    = 4;
   localparam int BYTE_W     = 8;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USED_W = PLANE_W + GROUP_W + BYTE_W;
   localparam int BIT_W      = $clog2(MAX_PLANES);

   localparam logic [PLANE_W-1:0] PLANE_RESET = PLANE_W'(MAX_PLANES);

   typedef struct packed {
      logic                sign;
      logic [SAMPLE_W-1:0] mag;
   } lane_out_type;

   typedef struct packed {
      logic [BYTE_W-1:0]                  sign_byte;
      logic [MAX_PLANES-1:0][BYTE_W-1:0]  mag_byte;
      logic [GROUP_W-1:0]                 group_index;
      logic [PLANE_W-1:0]                 plane_count;
   } group_type;

   function automatic logic [PLANE_W-1:0] clamp_planes(input logic [PLANE_W-1:0] value);
      logic [PLANE_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = PLANE_W'(1);
      end else if (value > PLANE_W'(MAX_PLANES)) begin
         result = PLANE_W'(MAX_PLANES);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### design/bitplane_sign_magnitude_pack_top.sv
// ----------------------------------------------------------------------------
// Bitplane sign-magnitude packer
// Splits groups of eight signed samples into a sign byte and magnitude bytes.
// ----------------------------------------------------------------------------
// Each request transaction carries eight samples and produces 1 + plane_count
// response transactions: the sign byte first, then one byte per kept magnitude
// plane from the top plane down to bit 0. The serializer sends one byte per
// cycle while the receiver is ready, and the next group is taken in the cycle
// its predecessor's last byte moves into the output register. Eight lanes work
// out sign and magnitude in parallel; a merge stage transposes them into
// plane bytes. plane_count values of zero act as one, values above sixteen
// act as sixteen; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bitplane_sign_magnitude_pack_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [bsmp_pkg::PLANE_W-1:0]       csr_wdata,   // plane_count
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // sample_0 .. sample_7 (16 bits each), valid_count (4 bits), zero fill
   input  wire logic [bsmp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tlast,   // final_group
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // plane_index (5 bits), group_index (12 bits), plane_byte (8 bits), zero fill
   output logic [bsmp_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tlast    // last_of_group
);
   import bsmp_pkg::*;

   logic [PLANE_W-1:0]  plane_count_ff, plane_count_in;
   logic [GROUP_W-1:0]  group_counter_ff, group_counter_in;
   logic [COUNT_W-1:0]  valid_count;
   logic                load;
   logic                free;
   lane_out_type [LANES-1:0] lanes;
   group_type           group;

   assign valid_count = req_tdata[LANES*SAMPLE_W +: COUNT_W];
   assign req_tready  = free;
   assign load        = req_tvalid && free;

   always_comb begin
      plane_count_in   = csr_wen ? csr_wdata : plane_count_ff;
      group_counter_in = group_counter_ff;
      if (load) begin
         group_counter_in = req_tlast ? '0 : group_counter_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff   <= PLANE_RESET;
         group_counter_ff <= '0;
      end else begin
         plane_count_ff   <= plane_count_in;
         group_counter_ff <= group_counter_in;
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      bsmp_lane u_lane (
         .sample   (req_tdata[k*SAMPLE_W +: SAMPLE_W]),
         .lane_en  (COUNT_W'(k) < valid_count),
         .lane_out (lanes[k])
      );
   end

   bsmp_merge u_merge (
      .clock       (clock),
      .load        (load),
      .lanes       (lanes),
      .group_index (group_counter_ff),
      .plane_count (clamp_planes(plane_count_ff)),
      .group       (group)
   );

   bsmp_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .group      (group),
      .load       (load),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### design/bsmp_lane.sv
// ----------------------------------------------------------------------------
// Bitplane packer lane
// Splits one sample into a sign bit and a magnitude, zero when the lane is unused.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmp_lane (
   input  wire logic [bsmp_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                          lane_en,
   output bsmp_pkg::lane_out_type             lane_out
);
   import bsmp_pkg::*;

   logic negative;

   assign negative      = sample[SAMPLE_W-1];
   assign lane_out.sign = lane_en & negative;
   assign lane_out.mag  = !lane_en ? '0 : (negative ? SAMPLE_W'(~sample + 1'b1) : sample);

endmodule

`default_nettype wire

### design/bsmp_merge.sv
// ----------------------------------------------------------------------------
// Bitplane packer merge stage
// Transposes the lane results into plane bytes and holds them for one group.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmp_merge (
   input  wire logic                                      clock,
   input  wire logic                                      load,
   input  wire bsmp_pkg::lane_out_type [bsmp_pkg::LANES-1:0] lanes,
   input  wire logic [bsmp_pkg::GROUP_W-1:0]              group_index,
   input  wire logic [bsmp_pkg::PLANE_W-1:0]              plane_count,
   output bsmp_pkg::group_type                            group
);
   import bsmp_pkg::*;

   group_type group_ff;
   group_type group_in;

   always_comb begin
      group_in = group_ff;
      if (load) begin
         for (int k = 0; k < LANES; k++) begin
            group_in.sign_byte[k] = lanes[k].sign;
            for (int p = 0; p < MAX_PLANES; p++) begin
               group_in.mag_byte[p][k] = lanes[k].mag[p];
            end
         end
         group_in.group_index = group_index;
         group_in.plane_count = plane_count;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   assign group = group_ff;

endmodule

`default_nettype wire

### design/bsmp_serial.sv
// ----------------------------------------------------------------------------
// Bitplane packer serializer
// Sends the held group one byte per transaction through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmp_serial (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bsmp_pkg::group_type               group,
   input  wire logic                              load,
   output logic                                   free,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bsmp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);
   import bsmp_pkg::*;

   logic                buf_valid_ff, buf_valid_in;
   logic [PLANE_W-1:0]  ptr_ff, ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PLANE_W-1:0]  plane_index_ff, plane_index_in;
   logic [GROUP_W-1:0]  group_index_ff, group_index_in;
   logic [BYTE_W-1:0]   plane_byte_ff, plane_byte_in;
   logic                last_ff, last_in;

   logic                out_load;
   logic                take;
   logic                buf_last;
   logic [PLANE_W-1:0]  bit_sel;

   assign out_load = !rsp_valid_ff || rsp_tready;
   assign take     = buf_valid_ff && out_load;
   assign buf_last = (ptr_ff == group.plane_count);
   assign free     = !buf_valid_ff || (take && buf_last);
   assign bit_sel  = group.plane_count - ptr_ff;

   always_comb begin
      buf_valid_in   = buf_valid_ff;
      ptr_in         = ptr_ff;
      rsp_valid_in   = rsp_valid_ff;
      plane_index_in = plane_index_ff;
      group_index_in = group_index_ff;
      plane_byte_in  = plane_byte_ff;
      last_in        = last_ff;
      if (take) begin
         ptr_in = ptr_ff + 1'b1;
         if (buf_last) begin
            buf_valid_in = 1'b0;
         end
      end
      if (load) begin
         buf_valid_in = 1'b1;
         ptr_in       = '0;
      end
      if (out_load) begin
         rsp_valid_in   = buf_valid_ff;
         plane_index_in = ptr_ff;
         group_index_in = group.group_index;
         plane_byte_in  = (ptr_ff == '0) ? group.sign_byte : group.mag_byte[bit_sel[BIT_W-1:0]];
         last_in        = buf_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_index_ff <= plane_index_in;
      group_index_ff <= group_index_in;
      plane_byte_ff  <= plane_byte_in;
      last_ff        <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), plane_byte_ff, group_index_ff,
                        plane_index_ff};

endmodule

`default_nettype wire

### design/bsmp_checker.sv
// ----------------------------------------------------------------------------
// Bitplane packer checker
// Port-level assertions on the response stream of the bitplane packer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitplane_sign_magnitude_pack_top_defines.svh"

module bsmp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [bsmp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                               rsp_tlast
);
   import bsmp_pkg::*;

   `BSMP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "Stalled response transaction changed.")
   `BSMP_ASSERT(a_sign_not_last, clock, reset, rsp_tvalid && (rsp_tdata[PLANE_W-1:0] == '0) |-> !rsp_tlast, "Sign byte marked as last of group.")
   `BSMP_ASSERT(a_plane_range, clock, reset, rsp_tvalid |-> rsp_tdata[PLANE_W-1:0] <= PLANE_W'(MAX_PLANES), "Plane index out of range.")
   `BSMP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "Response valid right after reset.")

endmodule

bind bitplane_sign_magnitude_pack_top bsmp_checker u_bsmp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### bench/bitplane_sign_magnitude_pack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitplane packer response checker
// Watches the register port and both stream channels of the packer. Every
// accepted request transaction is turned into the plane bytes it must cause,
// using a private copy of the plane count and the group counter. Every
// accepted response transaction is compared field by field with the oldest
// byte still outstanding. Mismatches and unexpected bytes are counted.
// ----------------------------------------------------------------------------

module bitplane_sign_magnitude_pack_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [bsmp_pkg::PLANE_W-1:0]       csr_wdata,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [bsmp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tlast,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [bsmp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                               rsp_tlast,
   output int                                      failure_count,
   output int                                      pending_count
);

   import bsmp_pkg::*;

   localparam logic [PLANE_W-1:0] SIGN_PLANE = '0;

   typedef struct packed {
      logic [PLANE_W-1:0] plane_index;
      logic [GROUP_W-1:0] group_index;
      logic [BYTE_W-1:0]  plane_byte;
      logic               last_of_group;
   } plane_byte_type;

   plane_byte_type     expected_bytes[$];
   logic [PLANE_W-1:0] plane_setting;
   logic [GROUP_W-1:0] group_count;

   function automatic void predict_group(input logic [REQ_DATA_W-1:0] data,
                                         input logic final_flag);
      logic [SAMPLE_W:0]   magnitude [LANES];
      logic [SAMPLE_W-1:0] raw;
      logic [BYTE_W-1:0]   signs;
      logic [BYTE_W-1:0]   bits;
      plane_byte_type      entry;
      int unsigned         valid;
      int unsigned         planes;
      int unsigned         bit_pos;
      valid = data[LANES*SAMPLE_W +: COUNT_W];
      if (valid > LANES) begin
         valid = LANES;
      end
      planes = plane_setting;
      if (planes == 0) begin
         planes = 1;
      end else if (planes > MAX_PLANES) begin
         planes = MAX_PLANES;
      end
      signs = '0;
      for (int lane = 0; lane < LANES; lane++) begin
         raw = data[lane*SAMPLE_W +: SAMPLE_W];
         magnitude[lane] = '0;
         if (lane < valid) begin
            signs[lane] = raw[SAMPLE_W-1];
            magnitude[lane] = raw[SAMPLE_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
         end
      end
      entry = '{SIGN_PLANE, group_count, signs, 1'b0};
      expected_bytes.push_back(entry);
      for (int p = 0; p < planes; p++) begin
         bit_pos = planes - 1 - p;
         for (int lane = 0; lane < LANES; lane++) begin
            bits[lane] = magnitude[lane][bit_pos];
         end
         entry = '{PLANE_W'(p + 1), group_count, bits, (p + 1 == planes)};
         expected_bytes.push_back(entry);
      end
      group_count = final_flag ? '0 : group_count + 1'b1;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         failure_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      plane_byte_type want;
      if (reset) begin
         plane_setting = PLANE_RESET;
         group_count = '0;
         expected_bytes.delete();
      end else begin
         if (csr_wen) begin
            plane_setting = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            predict_group(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("Response transaction with no byte expected: tdata %h", rsp_tdata);
               failure_count++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("plane_index", want.plane_index, rsp_tdata[0 +: PLANE_W]);
               check_field("group_index", want.group_index,
                           rsp_tdata[PLANE_W +: GROUP_W]);
               check_field("plane_byte", want.plane_byte,
                           rsp_tdata[PLANE_W+GROUP_W +: BYTE_W]);
               check_field("last_of_group", want.last_of_group, rsp_tlast);
            end
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

### bench/bitplane_sign_magnitude_pack_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitplane packer testbench
// Drives sample groups into the packer through a short directed set and a
// series of random phases, each under its own plane count, including the
// out-of-range counts and a long receiver stall. Both channels idle at
// random. A separate checker predicts and compares every plane byte; this
// module only makes stimulus and decides.
// ----------------------------------------------------------------------------

module bitplane_sign_magnitude_pack_top_test;

   import bsmp_pkg::*;

   localparam int GAP_MAX         = 12;
   localparam int LONG_HOLD       = 400;
   localparam int ITEMS_PER_PHASE = 30;
   localparam int DRAIN_LIMIT     = 100000;
   localparam int SETTLE_CYCLES   = 50;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wen    = 1'b0;
   logic [PLANE_W-1:0]    csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   int                    failures;
   int                    pending_bytes;
   bit                    source_quiet = 1'b0;
   bit                    sink_quiet   = 1'b0;
   bit                    long_hold    = 1'b0;

   always #1 clock = ~clock;

   bitplane_sign_magnitude_pack_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   bitplane_sign_magnitude_pack_checker byte_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .failure_count (failures),
      .pending_count (pending_bytes)
   );

   function automatic int next_gap();
      return source_quiet ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return SAMPLE_W'($urandom_range(0, 15));
         5: return SAMPLE_W'(-$urandom_range(1, 16));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [LANES*SAMPLE_W-1:0] random_lanes();
      logic [LANES*SAMPLE_W-1:0] lanes;
      for (int lane = 0; lane < LANES; lane++) begin
         lanes[lane*SAMPLE_W +: SAMPLE_W] = random_sample();
      end
      return lanes;
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      return ($urandom_range(0, 9) < 7) ? COUNT_W'(LANES) : COUNT_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [LANES*SAMPLE_W-1:0] walking_lanes(input int offset);
      logic [LANES*SAMPLE_W-1:0] lanes;
      for (int lane = 0; lane < LANES; lane++) begin
         lanes[lane*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(1) << (lane + offset);
      end
      return lanes;
   endfunction

   task automatic send_group(input logic [LANES*SAMPLE_W-1:0] samples,
                             input logic [COUNT_W-1:0] count,
                             input logic final_flag, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {{(REQ_DATA_W - LANES*SAMPLE_W - COUNT_W){1'b0}}, count, samples};
      req_tlast  <= final_flag;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (pending_bytes != 0) @(negedge clock);
   endtask

   task automatic write_plane_count(input logic [PLANE_W-1:0] setting);
      csr_wdata <= setting;
      csr_wen   <= 1'b1;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic run_phase(input logic [PLANE_W-1:0] setting);
      wait_idle();
      write_plane_count(setting);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         send_group(random_lanes(), random_count(), ($urandom_range(0, 7) == 0), next_gap());
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin : response_sink
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold) begin
            gap = LONG_HOLD;
            long_hold = 1'b0;
         end else if (sink_quiet) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, GAP_MAX);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin : timeout
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int cycles;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_group({LANES{16'h7FFF}}, COUNT_W'(8), 1'b0, next_gap());
      send_group({LANES{16'h8000}}, COUNT_W'(8), 1'b0, next_gap());
      send_group('0, COUNT_W'(8), 1'b0, next_gap());
      send_group({LANES{16'hFFFF}}, COUNT_W'(8), 1'b0, next_gap());
      send_group({4{16'h8000, 16'h7FFF}}, COUNT_W'(8), 1'b0, next_gap());
      send_group({4{16'h0001, 16'hFFFF}}, COUNT_W'(8), 1'b0, next_gap());
      send_group(walking_lanes(0), COUNT_W'(8), 1'b0, next_gap());
      send_group(walking_lanes(8), COUNT_W'(8), 1'b0, next_gap());
      send_group(random_lanes(), COUNT_W'(0), 1'b0, next_gap());
      send_group(random_lanes(), COUNT_W'(9), 1'b0, next_gap());
      send_group(random_lanes(), COUNT_W'(15), 1'b0, next_gap());
      send_group({LANES{16'h8000}}, COUNT_W'(5), 1'b1, next_gap());
      send_group(random_lanes(), COUNT_W'(1), 1'b1, next_gap());
      send_group(random_lanes(), COUNT_W'(8), 1'b1, next_gap());
      req_tvalid <= 1'b0;

      run_phase(PLANE_W'(1));
      run_phase(PLANE_W'(MAX_PLANES));
      run_phase('0);
      source_quiet = 1'b1;
      sink_quiet   = 1'b1;
      run_phase('1);
      source_quiet = 1'b0;
      sink_quiet   = 1'b0;
      run_phase(PLANE_W'(17));
      source_quiet = 1'b1;
      long_hold    = 1'b1;
      run_phase(PLANE_W'(2));
      source_quiet = 1'b0;
      run_phase(PLANE_W'(9));
      run_phase(PLANE_W'($urandom_range(1, MAX_PLANES)));

      cycles = 0;
      while (pending_bytes != 0 && cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         cycles++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_bytes == 0 && failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### bitplane_sign_magnitude_pack_top.f
+incdir+design
design/bsmp_pkg.sv
design/bsmp_lane.sv
design/bsmp_merge.sv
design/bsmp_serial.sv
design/bitplane_sign_magnitude_pack_top.sv
design/bsmp_checker.sv
bench/bitplane_sign_magnitude_pack_checker.sv
bench/bitplane_sign_magnitude_pack_top_test.sv
